// File: rtl/rbm_pkg.sv
// Shared types and constants for the RGBA blend mode unit.
package rbm_pkg;

   localparam int unsigned CHAN_W    = 8;
   localparam int unsigned PROD_W    = 2 * CHAN_W;
   localparam int unsigned WGT_W     = 16;
   localparam int unsigned NUM_W     = 25;
   localparam int unsigned DIV_STEPS = CHAN_W;

   typedef enum logic [3:0] {
      BLEND_PAINT      = 4'd0,
      BLEND_OVER       = 4'd1,
      BLEND_SUB        = 4'd2,
      BLEND_MAX        = 4'd3,
      BLEND_SUB_CLAMP  = 4'd4,
      BLEND_MUL_ALPHA  = 4'd5,
      BLEND_ISECT      = 4'd6,
      BLEND_ISECT_FILL = 4'd7,
      BLEND_PRODUCT    = 4'd8,
      BLEND_MIDPOINT   = 4'd9
   } mode_type;

   typedef struct packed {
      logic [3:0]        req_type;
      logic [CHAN_W-1:0] dst_red;
      logic [CHAN_W-1:0] dst_green;
      logic [CHAN_W-1:0] dst_blue;
      logic [CHAN_W-1:0] dst_alpha;
      logic [CHAN_W-1:0] src_red;
      logic [CHAN_W-1:0] src_green;
      logic [CHAN_W-1:0] src_blue;
      logic [CHAN_W-1:0] src_alpha;
   } req_word_type;

   typedef struct packed {
      logic [CHAN_W-1:0] out_red;
      logic [CHAN_W-1:0] out_green;
      logic [CHAN_W-1:0] out_blue;
      logic [CHAN_W-1:0] out_alpha;
   } rsp_word_type;

   // Word carried through the divider pipeline: over-mode partial
   // remainders and quotients per RGB channel plus the finished result.
   typedef struct packed {
      logic [2:0][NUM_W-1:0]  rem;
      logic [2:0][CHAN_W-1:0] quo;
      logic [WGT_W-1:0]       wgt;
      logic                   use_div;
      rsp_word_type           res;
   } div_word_type;

endpackage

// File: rtl/rbm_front.sv
// Front pipeline: channel products, simple blend modes and over-mode dividend.
module rbm_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  rbm_pkg::req_word_type in_data,
   output logic                out_valid,
   input  logic                out_ready,
   output rbm_pkg::div_word_type out_data
);
   import rbm_pkg::*;

   // Exact x/255 for any 16-bit x whose quotient fits in eight bits.
   function automatic logic [CHAN_W-1:0] div255(input logic [PROD_W-1:0] x);
      logic [PROD_W:0] t;
      t = {1'b0, x} + (PROD_W+1)'(1) + {{(CHAN_W+1){1'b0}}, x[PROD_W-1:CHAN_W]};
      return t[PROD_W-1:CHAN_W];
   endfunction

   logic s1_ready, s2_ready, s3_ready;

   // Stage 1 registers: operands and all 8x8 products.
   logic                   v1_ff;
   logic [3:0]             mode1_ff;
   logic [3:0][CHAN_W-1:0] d1_ff, d1_in;
   logic [3:0][CHAN_W-1:0] s1_ff, s1_in;
   logic [3:0][PROD_W-1:0] ds1_ff, ds1_in;
   logic [3:0][PROD_W-1:0] dsa1_ff, dsa1_in;
   logic [2:0][PROD_W-1:0] dinv1_ff, dinv1_in;
   logic [2:0][PROD_W-1:0] ssa1_ff, ssa1_in;
   logic [PROD_W-1:0]      dainv1_ff, dainv1_in;
   logic [CHAN_W-1:0]      inv_sa;

   // Stage 2 registers: simple-mode result and over-mode terms.
   logic                   v2_ff;
   rsp_word_type           res2_ff, res2_in;
   logic [2:0][23:0]       sc2_ff, sc2_in;
   logic [2:0][23:0]       pd2_ff, pd2_in;
   logic [WGT_W-1:0]       wgt2_ff, wgt2_in;
   logic                   over2_ff, over2_in;

   // Stage 3 register: word handed to the divider.
   logic                   v3_ff;
   div_word_type           w3_ff, w3_in;

   assign s3_ready = !v3_ff || out_ready;
   assign s2_ready = !v2_ff || s3_ready;
   assign s1_ready = !v1_ff || s2_ready;
   assign in_ready = s1_ready;

   // Stage 1 products.
   always_comb begin
      d1_in  = {in_data.dst_alpha, in_data.dst_blue, in_data.dst_green, in_data.dst_red};
      s1_in  = {in_data.src_alpha, in_data.src_blue, in_data.src_green, in_data.src_red};
      inv_sa = 8'd255 - in_data.src_alpha;
      for (int i = 0; i < 4; i++) begin
         ds1_in[i]  = PROD_W'(d1_in[i]) * PROD_W'(s1_in[i]);
         dsa1_in[i] = PROD_W'(d1_in[i]) * PROD_W'(in_data.src_alpha);
      end
      for (int i = 0; i < 3; i++) begin
         dinv1_in[i] = PROD_W'(d1_in[i]) * PROD_W'(inv_sa);
         ssa1_in[i]  = PROD_W'(s1_in[i]) * PROD_W'(in_data.src_alpha);
      end
      dainv1_in = PROD_W'(in_data.dst_alpha) * PROD_W'(inv_sa);
   end

   // Stage 2 mode decode and over-mode terms.
   always_comb begin
      logic [3:0][CHAN_W-1:0] r;
      logic [CHAN_W-1:0]      da, sa, amin;
      logic [CHAN_W:0]        mid;
      da   = d1_ff[3];
      sa   = s1_ff[3];
      amin = (da < sa) ? da : sa;
      mid  = '0;
      r    = d1_ff;
      unique case (mode_type'(mode1_ff))
         BLEND_PAINT: begin
            for (int i = 0; i < 3; i++) r[i] = div255(dinv1_ff[i] + ssa1_ff[i]);
         end
         BLEND_OVER: begin
            r[3] = sa + div255(dainv1_ff);
         end
         BLEND_SUB: begin
            r[3] = (da > sa) ? da - sa : '0;
         end
         BLEND_MAX: begin
            for (int i = 0; i < 3; i++) r[i] = s1_ff[i];
            r[3] = (da > sa) ? da : sa;
         end
         BLEND_SUB_CLAMP: begin
            r[3] = (da < 8'd255 - sa) ? da : 8'd255 - sa;
         end
         BLEND_MUL_ALPHA: begin
            for (int i = 0; i < 4; i++) r[i] = div255(dsa1_ff[i]);
         end
         BLEND_ISECT: begin
            r[3] = amin;
         end
         BLEND_ISECT_FILL: begin
            r[3] = amin;
            if (amin != '0) begin
               for (int i = 0; i < 3; i++) r[i] = s1_ff[i];
            end
         end
         BLEND_PRODUCT: begin
            for (int i = 0; i < 4; i++) r[i] = div255(ds1_ff[i]);
         end
         BLEND_MIDPOINT: begin
            for (int i = 0; i < 4; i++) begin
               mid  = {1'b0, d1_ff[i]} + {1'b0, s1_ff[i]};
               r[i] = mid[CHAN_W:1];
            end
         end
         default: begin
            r = d1_ff;
         end
      endcase
      res2_in = '{out_red: r[0], out_green: r[1], out_blue: r[2], out_alpha: r[3]};

      // Over mode: 255*s*sa and d*da*(255-sa) per channel, and the weight.
      for (int i = 0; i < 3; i++) begin
         sc2_in[i] = (24'(ssa1_ff[i]) << CHAN_W) - 24'(ssa1_ff[i]);
         pd2_in[i] = 24'(d1_ff[i]) * 24'(dainv1_ff);
      end
      wgt2_in  = ({sa, 8'h00} - {8'h00, sa}) + dainv1_ff;
      over2_in = (mode_type'(mode1_ff) == BLEND_OVER);
   end

   // Stage 3 dividend sum.
   always_comb begin
      w3_in = '0;
      for (int i = 0; i < 3; i++) w3_in.rem[i] = NUM_W'(sc2_ff[i]) + NUM_W'(pd2_ff[i]);
      w3_in.wgt     = wgt2_ff;
      w3_in.use_div = over2_ff && (wgt2_ff != '0);
      w3_in.res     = res2_ff;
   end

   // Valid bits.
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         if (s1_ready) v1_ff <= in_valid;
         if (s2_ready) v2_ff <= v1_ff;
         if (s3_ready) v3_ff <= v2_ff;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (s1_ready) begin
         mode1_ff  <= in_data.req_type;
         d1_ff     <= d1_in;
         s1_ff     <= s1_in;
         ds1_ff    <= ds1_in;
         dsa1_ff   <= dsa1_in;
         dinv1_ff  <= dinv1_in;
         ssa1_ff   <= ssa1_in;
         dainv1_ff <= dainv1_in;
      end
      if (s2_ready) begin
         res2_ff  <= res2_in;
         sc2_ff   <= sc2_in;
         pd2_ff   <= pd2_in;
         wgt2_ff  <= wgt2_in;
         over2_ff <= over2_in;
      end
      if (s3_ready) begin
         w3_ff <= w3_in;
      end
   end

   assign out_valid = v3_ff;
   assign out_data  = w3_ff;

endmodule

// File: rtl/rbm_div_step.sv
// One restoring-division stage: resolves one quotient bit for each RGB channel.
module rbm_div_step #(
   parameter int unsigned BIT = 0
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  rbm_pkg::div_word_type in_data,
   output logic                  out_valid,
   input  logic                  out_ready,
   output rbm_pkg::div_word_type out_data
);
   import rbm_pkg::*;

   logic         valid_ff;
   div_word_type word_ff, word_in;
   logic [NUM_W-1:0] trial;

   assign in_ready = !valid_ff || out_ready;

   // Subtract the shifted divisor where it fits and set this quotient bit.
   always_comb begin
      word_in = in_data;
      trial   = NUM_W'(in_data.wgt) << BIT;
      for (int c = 0; c < 3; c++) begin
         if (in_data.rem[c] >= trial) begin
            word_in.rem[c]      = in_data.rem[c] - trial;
            word_in.quo[c][BIT] = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready) begin
         word_ff <= word_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = word_ff;

endmodule

// File: rtl/rgba_blend_mode_unit.sv
// Top level of the RGBA blend mode unit: front pipeline, divider and output register.
// Throughput: one word per cycle unless rsp_ready stalls the chain; over-mode division
// runs as an 8-stage restoring divider, one quotient bit per stage, for all three
// RGB channels. Each stage holds its word on a stall and bubbles close up behind
// it. Reset clears all valid bits; payload registers are not reset.
module rgba_blend_mode_unit (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  rbm_pkg::req_word_type req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rbm_pkg::rsp_word_type rsp_data
);
   import rbm_pkg::*;

   logic [DIV_STEPS:0] div_valid;
   logic [DIV_STEPS:0] div_ready;
   div_word_type       div_data [DIV_STEPS+1];
   div_word_type       last_word;

   logic               rsp_valid_ff;
   rsp_word_type       rsp_data_ff, rsp_data_in;

   rbm_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_data   (req_data),
      .out_valid (div_valid[0]),
      .out_ready (div_ready[0]),
      .out_data  (div_data[0])
   );

   // Divider chain, most significant quotient bit first.
   for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
      rbm_div_step #(.BIT(DIV_STEPS - 1 - k)) u_step (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (div_valid[k]),
         .in_ready  (div_ready[k]),
         .in_data   (div_data[k]),
         .out_valid (div_valid[k+1]),
         .out_ready (div_ready[k+1]),
         .out_data  (div_data[k+1])
      );
   end

   assign last_word            = div_data[DIV_STEPS];
   assign div_ready[DIV_STEPS] = !rsp_valid_ff || rsp_ready;

   // Over mode takes the quotients; every other case keeps the front result.
   always_comb begin
      rsp_data_in = last_word.res;
      if (last_word.use_div) begin
         rsp_data_in.out_red   = last_word.quo[0];
         rsp_data_in.out_green = last_word.quo[1];
         rsp_data_in.out_blue  = last_word.quo[2];
      end
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (div_ready[DIV_STEPS]) begin
         rsp_valid_ff <= div_valid[DIV_STEPS];
      end
   end

   always_ff @(posedge clock) begin
      if (div_ready[DIV_STEPS]) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef SYNTH
   // Reset empties the output register.
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   // With the output register empty the whole chain is free to take a word.
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("request not ready while output is empty");

   // A finished over-mode division leaves remainders below the divisor.
   a_div_remainder: assert property (@(posedge clock) disable iff (reset)
      (div_valid[DIV_STEPS] && last_word.use_div) |->
      (last_word.rem[0] < NUM_W'(last_word.wgt)) &&
      (last_word.rem[1] < NUM_W'(last_word.wgt)) &&
      (last_word.rem[2] < NUM_W'(last_word.wgt)))
      else $error("divider remainder not below divisor");
`endif

endmodule
